>>> hw/rtl/wsfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser package
// Shared types, codes and constants of the receive frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] OPC_BINARY = 4'h2;
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    typedef enum logic [3:0] {
        PH_HDR0   = 4'd0,
        PH_HDR1   = 4'd1,
        PH_EXT_HI = 4'd2,
        PH_EXT_LO = 4'd3,
        PH_KEY0   = 4'd4,
        PH_KEY1   = 4'd5,
        PH_KEY2   = 4'd6,
        PH_KEY3   = 4'd7,
        PH_DATA   = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_EMPTY   = 2'd1,
        EV_ERROR   = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        ERR_FRAGMENTED = 2'd0,
        ERR_BINARY     = 2'd1,
        ERR_UNMASKED   = 2'd2,
        ERR_TOO_LARGE  = 2'd3
    } error_code_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] masked;
        logic [7:0] key;
        logic       last;
        logic [3:0] opcode;
        logic [1:0] err;
    } cmd_t;

endpackage

>>> hw/rtl/wsfp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one received frame byte per transaction.
// ----------------------------------------------------------------------------
interface wsfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

>>> hw/rtl/wsfp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event output channel
// Valid/ready channel carrying one parser event per transaction.
// ----------------------------------------------------------------------------
interface wsfp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] payload_byte;
    logic       last_of_message;
    logic [3:0] frame_opcode;
    logic [1:0] error_code;

    modport source (output valid, output event_kind, output payload_byte,
                    output last_of_message, output frame_opcode, output error_code,
                    input ready);
    modport sink (input valid, input event_kind, input payload_byte,
                  input last_of_message, input frame_opcode, input error_code,
                  output ready);
endinterface

>>> hw/rtl/websocket_frame_receive_parser.sv
`timescale 1ns / 1ps
// Path: an event reaches evt through the command queue and then the output register.
// Throughput: one byte per cycle; the front end stalls only when the
// two-entry command queue is full, which happens only under output stall.
// Reset: rst_n clears parse phase, frame fields, error halt, queue and
// output valid at once; no clearing pass.
// ----------------------------------------------------------------------------
// WebSocket frame receive parser
// Parses client-to-server frame headers and emits unmasked payload, empty-frame and error events.
// ----------------------------------------------------------------------------
module websocket_frame_receive_parser #(
    parameter int QueueDepth = wsfp_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    wsfp_in_if.sink    rx,
    wsfp_out_if.source evt
);

    logic           push;
    logic           space;
    logic           pop;
    logic           avail;
    wsfp_pkg::cmd_t push_cmd;
    wsfp_pkg::cmd_t pop_cmd;

    wsfp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .space (space),
        .push  (push),
        .cmd   (push_cmd)
    );

    wsfp_queue #(
        .DEPTH (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .space    (space),
        .pop      (pop),
        .avail    (avail),
        .pop_cmd  (pop_cmd)
    );

    wsfp_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .avail (avail),
        .cmd   (pop_cmd),
        .pop   (pop),
        .evt   (evt)
    );

endmodule

>>> hw/rtl/wsfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame header front end
// Accepts bytes, tracks header/key/payload phase and queues event commands.
// ----------------------------------------------------------------------------
module wsfp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    wsfp_in_if.sink              rx,
    input  logic                 space,
    output logic                 push,
    output wsfp_pkg::cmd_t       cmd
);

    wsfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       hdr0_reg, hdr0_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic [15:0]      len_reg, len_next;
    logic [15:0]      pos_reg, pos_next;
    logic [7:0]       key_reg [4];
    logic [7:0]       key_next [4];
    logic             halted_reg, halted_next;

    logic             accept;
    logic [15:0]      pos_inc;
    logic [6:0]       len_code;
    logic [3:0]       hdr_opc;
    logic             err_hit;
    logic [1:0]       err_sel;

    assign rx.ready = space;
    assign accept   = rx.valid && rx.ready;
    assign pos_inc  = 16'(pos_reg + 16'd1);
    assign len_code = rx.data_byte[6:0];
    assign hdr_opc  = hdr0_reg[3:0];

    always_comb
    begin
        err_hit = 1'b1;
        err_sel = wsfp_pkg::ERR_FRAGMENTED;
        priority if (!hdr0_reg[7])
        begin
            err_sel = wsfp_pkg::ERR_FRAGMENTED;
        end
        else if (hdr_opc == wsfp_pkg::OPC_BINARY)
        begin
            err_sel = wsfp_pkg::ERR_BINARY;
        end
        else if (!rx.data_byte[7])
        begin
            err_sel = wsfp_pkg::ERR_UNMASKED;
        end
        else if (len_code == wsfp_pkg::LEN_CODE_EXT64)
        begin
            err_sel = wsfp_pkg::ERR_TOO_LARGE;
        end
        else
        begin
            err_hit = 1'b0;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        hdr0_next   = hdr0_reg;
        opcode_next = opcode_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        key_next    = key_reg;
        halted_next = halted_reg;
        push        = 1'b0;
        cmd.kind    = wsfp_pkg::EV_PAYLOAD;
        cmd.masked  = 8'd0;
        cmd.key     = 8'd0;
        cmd.last    = 1'b0;
        cmd.opcode  = opcode_reg;
        cmd.err     = wsfp_pkg::ERR_FRAGMENTED;

        if (accept && !halted_reg)
        begin
            unique case (phase_reg)
                wsfp_pkg::PH_HDR0:
                begin
                    hdr0_next  = rx.data_byte;
                    phase_next = wsfp_pkg::PH_HDR1;
                end
                wsfp_pkg::PH_HDR1:
                begin
                    opcode_next = hdr_opc;
                    if (err_hit)
                    begin
                        halted_next = 1'b1;
                        push        = 1'b1;
                        cmd.kind    = wsfp_pkg::EV_ERROR;
                        cmd.opcode  = hdr_opc;
                        cmd.err     = err_sel;
                    end
                    else if (len_code < wsfp_pkg::LEN_CODE_EXT16)
                    begin
                        len_next   = {9'd0, len_code};
                        phase_next = wsfp_pkg::PH_KEY0;
                    end
                    else
                    begin
                        phase_next = wsfp_pkg::PH_EXT_HI;
                    end
                end
                wsfp_pkg::PH_EXT_HI:
                begin
                    len_next   = {rx.data_byte, 8'd0};
                    phase_next = wsfp_pkg::PH_EXT_LO;
                end
                wsfp_pkg::PH_EXT_LO:
                begin
                    len_next   = {len_reg[15:8], rx.data_byte};
                    phase_next = wsfp_pkg::PH_KEY0;
                end
                wsfp_pkg::PH_KEY0:
                begin
                    key_next[0] = rx.data_byte;
                    phase_next  = wsfp_pkg::PH_KEY1;
                end
                wsfp_pkg::PH_KEY1:
                begin
                    key_next[1] = rx.data_byte;
                    phase_next  = wsfp_pkg::PH_KEY2;
                end
                wsfp_pkg::PH_KEY2:
                begin
                    key_next[2] = rx.data_byte;
                    phase_next  = wsfp_pkg::PH_KEY3;
                end
                wsfp_pkg::PH_KEY3:
                begin
                    key_next[3] = rx.data_byte;
                    pos_next    = 16'd0;
                    if (len_reg == 16'd0)
                    begin
                        push        = 1'b1;
                        cmd.kind    = wsfp_pkg::EV_EMPTY;
                        cmd.last    = 1'b1;
                        phase_next  = wsfp_pkg::PH_HDR0;
                        hdr0_next   = 8'd0;
                        opcode_next = 4'd0;
                        for (int i = 0; i < 4; i++)
                        begin
                            key_next[i] = 8'd0;
                        end
                    end
                    else
                    begin
                        phase_next = wsfp_pkg::PH_DATA;
                    end
                end
                wsfp_pkg::PH_DATA:
                begin
                    push       = 1'b1;
                    cmd.kind   = wsfp_pkg::EV_PAYLOAD;
                    cmd.masked = rx.data_byte;
                    cmd.key    = key_reg[pos_reg[1:0]];
                    cmd.last   = (pos_inc == len_reg);
                    pos_next   = pos_inc;
                    if (pos_inc == len_reg)
                    begin
                        phase_next  = wsfp_pkg::PH_HDR0;
                        hdr0_next   = 8'd0;
                        opcode_next = 4'd0;
                        len_next    = 16'd0;
                        pos_next    = 16'd0;
                        for (int i = 0; i < 4; i++)
                        begin
                            key_next[i] = 8'd0;
                        end
                    end
                end
                default:
                begin
                    hdr0_next  = rx.data_byte;
                    phase_next = wsfp_pkg::PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsfp_pkg::PH_HDR0;
            hdr0_reg   <= 8'd0;
            opcode_reg <= 4'd0;
            len_reg    <= 16'd0;
            pos_reg    <= 16'd0;
            halted_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= 8'd0;
            end
        end
        else
        begin
            phase_reg  <= phase_next;
            hdr0_reg   <= hdr0_next;
            opcode_reg <= opcode_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            halted_reg <= halted_next;
            key_reg    <= key_next;
        end
    end

endmodule

>>> hw/rtl/wsfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO between the header front end and the event back end.
// ----------------------------------------------------------------------------
module wsfp_queue #(
    parameter int DEPTH = wsfp_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wsfp_pkg::cmd_t push_cmd,
    output logic           space,
    input  logic           pop,
    output logic           avail,
    output wsfp_pkg::cmd_t pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wsfp_pkg::cmd_t mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign space   = (count_reg != CW'(DEPTH));
    assign avail   = (count_reg != '0);
    assign do_push = push && space;
    assign do_pop  = pop && avail;
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = CW'(count_reg + 1'b1);
            2'b01:   count_next = CW'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hw/rtl/wsfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event back end
// Unmasks payload bytes and holds each event in the output register.
// ----------------------------------------------------------------------------
module wsfp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           avail,
    input  wsfp_pkg::cmd_t cmd,
    output logic           pop,
    wsfp_out_if.source     evt
);

    logic       valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic [3:0] opc_reg;
    logic [1:0] err_reg;

    assign pop = avail && (!valid_reg || evt.ready);

    assign evt.valid           = valid_reg;
    assign evt.event_kind      = kind_reg;
    assign evt.payload_byte    = byte_reg;
    assign evt.last_of_message = last_reg;
    assign evt.frame_opcode    = opc_reg;
    assign evt.error_code      = err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (evt.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= cmd.kind;
            byte_reg <= cmd.masked ^ cmd.key;
            last_reg <= cmd.last;
            opc_reg  <= cmd.opcode;
            err_reg  <= cmd.err;
        end
    end

endmodule

>>> bench/wsfp_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame parser event checker
// Watches the byte and event channels, tracks the frame parse of every
// accepted byte, and compares each accepted event field by field with the
// oldest predicted event.
// ----------------------------------------------------------------------------
module wsfp_event_checker (
    input  logic clk,
    input  logic rst_n,
    wsfp_in_if   rx,
    wsfp_out_if  evt,
    output int   mismatches,
    output int   outstanding
);

    typedef struct {
        wsfp_pkg::event_kind_t kind;
        logic [7:0]            data;
        logic                  last;
        logic [3:0]            opcode;
        wsfp_pkg::error_code_t err;
    } frame_event_t;

    frame_event_t pending_events[$];

    wsfp_pkg::phase_t phase;
    logic [7:0]       hdr0;
    logic [3:0]       opcode;
    logic [15:0]      length;
    logic [15:0]      position;
    logic [7:0]       key[4];
    logic             halted;

    task automatic clear_frame();
        phase    = wsfp_pkg::PH_HDR0;
        hdr0     = '0;
        opcode   = '0;
        length   = '0;
        position = '0;
        for (int i = 0; i < 4; i++)
        begin
            key[i] = '0;
        end
    endtask

    // error_code reads as zero on anything but an error event
    task automatic push_event(input wsfp_pkg::event_kind_t kind, input logic [7:0] data,
                              input logic last, input wsfp_pkg::error_code_t err);
        frame_event_t ev;
        ev.kind   = kind;
        ev.data   = data;
        ev.last   = last;
        ev.opcode = opcode;
        ev.err    = err;
        pending_events.push_back(ev);
    endtask

    task automatic predict_frame_byte(input logic [7:0] b);
        logic [6:0]            code;
        logic                  bad;
        wsfp_pkg::error_code_t err;
        logic                  done;
        if (halted)
        begin
            return;
        end
        case (phase)
            wsfp_pkg::PH_HDR1:
            begin
                code   = b[6:0];
                opcode = hdr0[3:0];
                bad    = 1'b1;
                err    = wsfp_pkg::ERR_FRAGMENTED;
                if (!hdr0[7])
                    err = wsfp_pkg::ERR_FRAGMENTED;
                else if (opcode == wsfp_pkg::OPC_BINARY)
                    err = wsfp_pkg::ERR_BINARY;
                else if (!b[7])
                    err = wsfp_pkg::ERR_UNMASKED;
                else if (code == wsfp_pkg::LEN_CODE_EXT64)
                    err = wsfp_pkg::ERR_TOO_LARGE;
                else
                    bad = 1'b0;
                if (bad)
                begin
                    halted = 1'b1;
                    push_event(wsfp_pkg::EV_ERROR, 8'h00, 1'b0, err);
                end
                else if (code < wsfp_pkg::LEN_CODE_EXT16)
                begin
                    length = {9'd0, code};
                    phase  = wsfp_pkg::PH_KEY0;
                end
                else
                begin
                    phase = wsfp_pkg::PH_EXT_HI;
                end
            end
            wsfp_pkg::PH_EXT_HI:
            begin
                length = {b, 8'h00};
                phase  = wsfp_pkg::PH_EXT_LO;
            end
            wsfp_pkg::PH_EXT_LO:
            begin
                length[7:0] = b;
                phase       = wsfp_pkg::PH_KEY0;
            end
            wsfp_pkg::PH_KEY0, wsfp_pkg::PH_KEY1, wsfp_pkg::PH_KEY2:
            begin
                key[phase[1:0]] = b;
                phase = wsfp_pkg::phase_t'(phase + 1);
            end
            wsfp_pkg::PH_KEY3:
            begin
                key[3] = b;
                if (length == 16'd0)
                begin
                    push_event(wsfp_pkg::EV_EMPTY, 8'h00, 1'b1, wsfp_pkg::ERR_FRAGMENTED);
                    clear_frame();
                end
                else
                begin
                    position = '0;
                    phase    = wsfp_pkg::PH_DATA;
                end
            end
            wsfp_pkg::PH_DATA:
            begin
                done = (position + 16'd1 == length);
                push_event(wsfp_pkg::EV_PAYLOAD, b ^ key[position[1:0]], done,
                           wsfp_pkg::ERR_FRAGMENTED);
                position = position + 16'd1;
                if (done)
                    clear_frame();
            end
            default:
            begin
                hdr0  = b;
                phase = wsfp_pkg::PH_HDR1;
            end
        endcase
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_event_t want;
        if (!rst_n)
        begin
            clear_frame();
            halted = 1'b0;
            pending_events.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rx.valid && rx.ready)
                predict_frame_byte(rx.data_byte);
            if (evt.valid && evt.ready)
            begin
                if (pending_events.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: event expected none actual kind %0h byte %0h last %0h",
                             $time, evt.event_kind, evt.payload_byte, evt.last_of_message);
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("event_kind", 32'(want.kind), 32'(evt.event_kind));
                    check_field("payload_byte", 32'(want.data), 32'(evt.payload_byte));
                    check_field("last_of_message", 32'(want.last),
                                32'(evt.last_of_message));
                    check_field("frame_opcode", 32'(want.opcode), 32'(evt.frame_opcode));
                    check_field("error_code", 32'(want.err), 32'(evt.error_code));
                end
            end
            outstanding <= pending_events.size();
        end
    end

endmodule

>>> bench/websocket_frame_receive_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame receive parser testbench
// Sends directed and random masked frames with random gaps and output
// stalls, then one malformed frame followed by bytes that must be dropped.
// The checker predicts and compares every event.
// ----------------------------------------------------------------------------
module websocket_frame_receive_parser_tb;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int RANDOM_BYTES = 750;
    localparam int TAIL_CYCLES = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   steady = 1'b0;
    int   bytes_sent = 0;
    int   cycle_count = 0;
    int   mismatches;
    int   outstanding;

    wsfp_in_if  rx_bus ();
    wsfp_out_if evt_bus ();

    websocket_frame_receive_parser DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_bus.sink),
        .evt   (evt_bus.source)
    );

    wsfp_event_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx_bus),
        .evt         (evt_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // empty short frame, empty extended frame with RSV bits, 3-byte frame
    logic [7:0] directed_bytes[23] = '{
        8'h81, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hF0, 8'hFE, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44,
        8'h8F, 8'h83, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h3C
    };

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        evt_bus.ready <= steady || ($urandom_range(99) >= 20);
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(99) < 20)
        begin
            rx_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        rx_bus.valid     <= 1'b1;
        rx_bus.data_byte <= b;
        do
            @(posedge clk);
        while (!rx_bus.ready);
        bytes_sent++;
    endtask

    task automatic drain();
        rx_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic pick_opcode(output logic [3:0] op);
        do
            op = 4'($urandom_range(15));
        while (op == wsfp_pkg::OPC_BINARY);
    endtask

    task automatic send_frame(input bit ext, input logic [15:0] len);
        logic [3:0] op;
        logic [2:0] rsv;
        pick_opcode(op);
        rsv = 3'($urandom_range(7));
        send_byte({1'b1, rsv, op});
        if (ext)
        begin
            send_byte({1'b1, wsfp_pkg::LEN_CODE_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        else
        begin
            send_byte({1'b1, len[6:0]});
        end
        repeat (4) send_byte(8'($urandom_range(255)));
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_bad_frame();
        wsfp_pkg::error_code_t flaw;
        logic [3:0]            op;
        logic [2:0]            rsv;
        flaw = wsfp_pkg::error_code_t'($urandom_range(3));
        pick_opcode(op);
        rsv = 3'($urandom_range(7));
        case (flaw)
            wsfp_pkg::ERR_FRAGMENTED:
            begin
                send_byte({1'b0, rsv, 4'($urandom_range(15))});
                send_byte(8'($urandom_range(255)));
            end
            wsfp_pkg::ERR_BINARY:
            begin
                send_byte({1'b1, rsv, wsfp_pkg::OPC_BINARY});
                send_byte(8'($urandom_range(255)));
            end
            wsfp_pkg::ERR_UNMASKED:
            begin
                send_byte({1'b1, rsv, op});
                send_byte({1'b0, 7'($urandom_range(127))});
            end
            default:
            begin
                send_byte({1'b1, rsv, op});
                send_byte({1'b1, wsfp_pkg::LEN_CODE_EXT64});
            end
        endcase
        // parser is halted; these must be dropped silently
        repeat (16) send_byte(8'($urandom_range(255)));
    endtask

    initial
    begin
        int  random_start;
        int  roll;
        bit  paused;
        rx_bus.valid     <= 1'b0;
        rx_bus.data_byte <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        drain();

        random_start = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            steady = (bytes_sent - random_start >= 250) && (bytes_sent - random_start < 400);
            if (!paused && bytes_sent - random_start >= 500)
            begin
                paused = 1'b1;
                drain();
            end
            roll = $urandom_range(99);
            if (roll < 10)
                send_frame(1'b0, 16'd0);
            else if (roll < 65)
                send_frame(1'b0, 16'($urandom_range(1, 16)));
            else if (roll < 80)
                send_frame(1'b0, 16'($urandom_range(17, 125)));
            else if (roll < 88)
                send_frame(1'b1, 16'($urandom_range(0, 127)));
            else
                send_frame(1'b1, 16'($urandom_range(126, 400)));
        end
        steady = 1'b0;

        send_frame(1'b1, 16'd126);
        send_bad_frame();
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
